// ===== rtl/core/prsd_pkg.sv =====
// Shared types, constants and the seven-segment encoder for the pulse-rate
// speedometer display core.
// No dependencies; imported by every module of the block.
package prsd_pkg;

   // Default parameter values
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int MAX_SHOWN_DEF   = 999;

   // Register widths and reset values
   localparam int SCALE_W   = 16;
   localparam int FACTOR_W  = 18;
   localparam int STEP_W    = 8;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1800);
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(105469);
   localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(10);

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_DISTANCE_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNIT_FACTOR_Q16 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_STEP       = 2'd2;

   // Speed arithmetic. Any base at or above 2^26 with a nonzero factor
   // already gives a speed of at least 1024, so base is clamped there.
   localparam int FACTOR_FRAC   = 16;
   localparam int BASE_CLAMP_W  = 26;
   localparam int BASE_W        = BASE_CLAMP_W + 1;
   localparam int SCALED_W      = BASE_W + FACTOR_W;
   localparam int SPEED_FULL_W  = SCALED_W - FACTOR_FRAC;
   localparam logic [BASE_W-1:0] BASE_LIMIT = BASE_W'(1) << BASE_CLAMP_W;

   // Display
   localparam int SPEED_W = 10;
   localparam int DIGIT_W = 4;
   localparam int SEG_W   = 8;
   localparam logic [SEG_W-1:0]   SEG_BLANK = 8'hFF;
   localparam logic [SPEED_W-1:0] HUNDRED   = SPEED_W'(100);
   localparam logic [SPEED_W-1:0] TEN       = SPEED_W'(10);

   // Status of an iterative unit toward its sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } prsd_unit_status_type;

   // Active-low seven-segment pattern of one decimal digit
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

// ===== rtl/core/prsd_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on prsd_pkg for the status struct.
module prsd_div #(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIVIDEND_W-1:0]        dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output prsd_pkg::prsd_unit_status_type status,
   output logic [DIVIDEND_W-1:0]        quotient
);
   import prsd_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;

   // Shift in the next dividend bit and try the subtract
   assign trial  = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff   = trial - {1'b0, divisor};
   assign fits   = (trial >= {1'b0, divisor});
   assign rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

// ===== rtl/core/prsd_digit.sv =====
// Decimal digit extraction by repeated subtraction and segment encoding.
// Depends on prsd_pkg for widths, the status struct and seg_of.
module prsd_digit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [prsd_pkg::SPEED_W-1:0]   value,
   output prsd_pkg::prsd_unit_status_type status,
   output logic [prsd_pkg::SEG_W-1:0]     hundreds_seg,
   output logic [prsd_pkg::SEG_W-1:0]     tens_seg,
   output logic [prsd_pkg::SEG_W-1:0]     units_seg
);
   import prsd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HUND,
      PH_TENS
   } phase_type;

   phase_type            phase_ff;
   logic [SPEED_W-1:0]   work_ff;
   logic [DIGIT_W-1:0]   hund_ff;
   logic [DIGIT_W-1:0]   tens_ff;
   logic                 done_ff;

   // Take off one hundred or one ten per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  work_ff  <= value;
                  hund_ff  <= '0;
                  tens_ff  <= '0;
                  phase_ff <= PH_HUND;
               end
            end
            PH_HUND: begin
               if (work_ff >= HUNDRED) begin
                  work_ff <= work_ff - HUNDRED;
                  hund_ff <= hund_ff + 1'b1;
               end else begin
                  phase_ff <= PH_TENS;
               end
            end
            PH_TENS: begin
               if (work_ff >= TEN) begin
                  work_ff <= work_ff - TEN;
                  tens_ff <= tens_ff + 1'b1;
               end else begin
                  done_ff  <= 1'b1;
                  phase_ff <= PH_IDLE;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   // Encode digits; the remainder left over is the units digit
   assign hundreds_seg = seg_of(hund_ff);
   assign tens_seg     = seg_of(tens_ff);
   assign units_seg    = seg_of(work_ff[DIGIT_W-1:0]);

   assign status.busy = (phase_ff != PH_IDLE);
   assign status.done = done_ff;

endmodule

// ===== rtl/core/pulse_rate_speedometer_display_core.sv =====
// Top level of the pulse-rate speedometer display core: input edge logic,
// counters, sequencer, speed scaling and result register.
// Depends on prsd_pkg, prsd_div and prsd_digit.
//
// Usage:
//   req_ carries one beat per pin sample (req_tuser = 0) or timer tick
//   (req_tuser = 1). A rising button level toggles the unit flag, a rising
//   pulse level counts one wheel pulse, a tick adds tick_step to the time.
//   rsp_ returns exactly one beat per request: the three active-low display
//   digits and the two unit LEDs. A speed above MAX_SHOWN, or a time of zero,
//   leaves the digits as they were; after reset they are all dark.
//   csr_ writes distance_scale, unit_factor_q16 and tick_step by index; it is
//   always ready. It must be written only while no request is in flight; the
//   block itself does not enforce this.
// Timing:
//   One request at a time. A request passes the setup step, the divide
//   stage (load, COUNT_WIDTH + 16 quotient bits, handoff), scaling, the
//   range check and digit extraction before its result is loaded; a zero
//   time goes from setup straight to loading the result. The divider and
//   the digit subtract loop are iterative. req_tready is high only while
//   the sequencer is idle, from the cycle the result is loaded. The result
//   sits in an output register; a new request is taken while it waits, and
//   its own result waits until rsp_ drains. Reset is synchronous and
//   returns the registers to their defaults and the counters to zero.
module pulse_rate_speedometer_display_core #(
   parameter int COUNT_WIDTH = prsd_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_SHOWN   = prsd_pkg::MAX_SHOWN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] button_level, [1] pulse_level
   input  logic                              req_tuser,  // [0] mode
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // [7:0] hundreds_segments,
                                                         // [15:8] tens_segments,
                                                         // [23:16] units_segments,
                                                         // [24] led_flag_clear,
                                                         // [25] led_flag_set
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [prsd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [prsd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import prsd_pkg::*;

   localparam int PROD_W = COUNT_WIDTH + SCALE_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SCALE,
      ST_CHECK,
      ST_DIGIT,
      ST_DONE
   } state_type;

   state_type             state_ff;

   // configuration
   logic [SCALE_W-1:0]    scale_ff;
   logic [FACTOR_W-1:0]   factor_ff;
   logic [STEP_W-1:0]     step_ff;

   // speedometer state
   logic                  flag_ff;
   logic                  prev_button_ff;
   logic                  prev_pulse_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] time_ff;
   logic [SEG_W-1:0]      shown_h_ff;
   logic [SEG_W-1:0]      shown_t_ff;
   logic [SEG_W-1:0]      shown_u_ff;

   // datapath
   logic [PROD_W-1:0]       prod_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [SPEED_FULL_W-1:0] speed_ff;
   logic                    div_start_ff;
   logic                    dig_start_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_data_ff;

   logic                  accept;
   logic                  button_level;
   logic                  pulse_level;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH:0]   time_sum;
   logic [COUNT_WIDTH-1:0] time_in;
   logic [PROD_W-1:0]      prod_in;
   logic [BASE_W-1:0]      base_in;
   logic [SCALED_W-1:0]    scaled;
   logic [SPEED_FULL_W-1:0] speed_in;

   logic [PROD_W-1:0]      quotient;
   prsd_unit_status_type   div_status;
   prsd_unit_status_type   dig_status;
   logic [SEG_W-1:0]       dig_h;
   logic [SEG_W-1:0]       dig_t;
   logic [SEG_W-1:0]       dig_u;

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign button_level = req_tdata[0];
   assign pulse_level  = req_tdata[1];

   // Saturating counter updates
   assign count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign time_sum = {1'b0, time_ff} + (COUNT_WIDTH+1)'(step_ff);
   assign time_in  = time_sum[COUNT_WIDTH] ? CNT_MAX : time_sum[COUNT_WIDTH-1:0];

   // Pulses times scale, then clamp the quotient and apply the unit factor unless the unit flag is set
   assign prod_in  = {{SCALE_W{1'b0}}, count_ff} * {{COUNT_WIDTH{1'b0}}, scale_ff};
   assign base_in  = (|quotient[PROD_W-1:BASE_CLAMP_W]) ? BASE_LIMIT
                     : {1'b0, quotient[BASE_CLAMP_W-1:0]};
   assign scaled   = {{FACTOR_W{1'b0}}, base_ff} * {{BASE_W{1'b0}}, factor_ff};
   assign speed_in = flag_ff ? SPEED_FULL_W'(base_ff) : scaled[SCALED_W-1:FACTOR_FRAC];

   prsd_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (time_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   prsd_digit u_digit (
      .clock        (clock),
      .reset        (reset),
      .start        (dig_start_ff),
      .value        (speed_ff[SPEED_W-1:0]),
      .status       (dig_status),
      .hundreds_seg (dig_h),
      .tens_seg     (dig_t),
      .units_seg    (dig_u)
   );

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         factor_ff <= FACTOR_RESET;
         step_ff   <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DISTANCE_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            REG_UNIT_FACTOR_Q16: factor_ff <= csr_data[FACTOR_W-1:0];
            REG_TICK_STEP:       step_ff   <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer with item state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         flag_ff        <= 1'b0;
         prev_button_ff <= 1'b0;
         prev_pulse_ff  <= 1'b0;
         count_ff       <= '0;
         time_ff        <= '0;
         shown_h_ff     <= SEG_BLANK;
         shown_t_ff     <= SEG_BLANK;
         shown_u_ff     <= SEG_BLANK;
         div_start_ff   <= 1'b0;
         dig_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         dig_start_ff <= 1'b0;
         // drop a drained beat unless the done state reloads it this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser) begin
                     time_ff <= time_in;
                  end else begin
                     if (button_level && !prev_button_ff) begin
                        flag_ff <= !flag_ff;
                     end
                     if (pulse_level && !prev_pulse_ff) begin
                        count_ff <= count_in;
                     end
                     prev_button_ff <= button_level;
                     prev_pulse_ff  <= pulse_level;
                  end
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // zero time gives no speed: hold the display
               if (time_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  prod_ff      <= prod_in;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_status.done) begin
                  base_ff  <= base_in;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               speed_ff <= speed_in;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (speed_ff > SPEED_FULL_W'(MAX_SHOWN)) begin
                  state_ff <= ST_DONE;
               end else begin
                  dig_start_ff <= 1'b1;
                  state_ff     <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (dig_status.done) begin
                  shown_h_ff <= dig_h;
                  shown_t_ff <= dig_t;
                  shown_u_ff <= dig_u;
                  state_ff   <= ST_DONE;
               end
            end
            ST_DONE: begin
               // load the result once the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'b0, flag_ff, !flag_ff,
                                   shown_u_ff, shown_t_ff, shown_h_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Divider is never running while a new beat can be taken
   a_div_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("divider busy while request channel ready");

   // Divider completion only arrives while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   // Digit completion only arrives while the sequencer waits for it
   a_dig_done_state: assert property (@(posedge clock) disable iff (reset)
      dig_status.done |-> (state_ff == ST_DIGIT))
      else $error("digit unit done outside digit state");

   // Elapsed time never decreases on a tick
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (time_ff >= $past(time_ff)))
      else $error("elapsed time decreased on tick");

endmodule
